>>> rtl/ppdc_pkg.sv
package ppdc_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_CURVE_GAIN    = 3'd0,
		CFG_VELOCITY_GAIN = 3'd1,
		CFG_MAX_VELOCITY  = 3'd2,
		CFG_LOOKAHEAD     = 3'd3,
		CFG_ANGULAR_GAIN  = 3'd4,
		CFG_STOP_DISTANCE = 3'd5
	} cfg_idx_t;

	// cordic datapath width, q30 vectors and q29 angles
	localparam int CW = 34;

	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] PI_Q29       = 34'sd1686629713;
	localparam logic signed [CW-1:0] HALF_PI_Q29  = 34'sd843314857;

	// arctangent of 2^-i in q29
	function automatic logic signed [CW-1:0] atan_q29(input int idx);
		logic signed [CW-1:0] r;
		case (idx)
			0:       r = 34'sd421657428;
			1:       r = 34'sd248918915;
			2:       r = 34'sd131521918;
			3:       r = 34'sd66762579;
			4:       r = 34'sd33510843;
			5:       r = 34'sd16771758;
			6:       r = 34'sd8387925;
			7:       r = 34'sd4194219;
			8:       r = 34'sd2097141;
			9:       r = 34'sd1048575;
			10:      r = 34'sd524288;
			11:      r = 34'sd262144;
			12:      r = 34'sd131072;
			13:      r = 34'sd65536;
			14:      r = 34'sd32768;
			15:      r = 34'sd16384;
			16:      r = 34'sd8192;
			17:      r = 34'sd4096;
			18:      r = 34'sd2048;
			19:      r = 34'sd1024;
			20:      r = 34'sd512;
			21:      r = 34'sd256;
			22:      r = 34'sd128;
			23:      r = 34'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/pure_pursuit_drive_command_unit.sv
// pure pursuit drive command unit
//
// input channel: in_valid / in_stall carry one item per pose: pose_x, pose_y,
// heading (q3.13 radians) and target_x, target_y. output channel: out_valid /
// out_stall carry linear_velocity (integer), angular_velocity (q16.8,
// saturating) and arrived. an item moves at a clock edge where valid is high
// and stall is low. configuration goes through cfg_we / cfg_index / cfg_data,
// one register per write, to be taken while no item is in flight: the user
// must keep to this, as the block itself does not enforce it.
// every item gives exactly one result, in order, through the bit-serial
// pipelines: the cordic rotation, the 25 stage square root and the three
// long dividers (43, 24 and 34 stages). one item can enter every cycle
// while in_stall is low.
//
// reset clears all valid bits, the output queue and loads the register
// defaults. a two-entry queue sits at the output: while a result waits under
// out_stall the pipeline keeps moving until the queue is full, and only then
// in_stall rises and the whole pipeline holds.
module pure_pursuit_drive_command_unit import ppdc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        linear_velocity,
	output logic signed [23:0] angular_velocity,
	output logic               arrived,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// ---------------- configuration registers ----------------
	logic [15:0] curve_gain_q;
	logic [15:0] velocity_gain_q;
	logic [15:0] max_velocity_q;
	logic [14:0] lookahead_q;
	logic [15:0] angular_gain_q;
	logic [14:0] stop_distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_gain_q    <= 16'd256;
			velocity_gain_q <= 16'd256;
			max_velocity_q  <= 16'd1000;
			lookahead_q     <= 15'd100;
			angular_gain_q  <= 16'd256;
			stop_distance_q <= 15'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CURVE_GAIN:    curve_gain_q    <= cfg_data;
				CFG_VELOCITY_GAIN: velocity_gain_q <= cfg_data;
				CFG_MAX_VELOCITY:  max_velocity_q  <= cfg_data;
				CFG_LOOKAHEAD:     lookahead_q     <= cfg_data[14:0];
				CFG_ANGULAR_GAIN:  angular_gain_q  <= cfg_data;
				CFG_STOP_DISTANCE: stop_distance_q <= cfg_data[14:0];
				default: ;   // unknown index, write dropped
			endcase
		end
	end

	// ---------------- global advance ----------------
	// whole pipeline moves together; it holds only when the output queue is full
	logic       en;
	logic [1:0] cnt_q;

	assign en       = (cnt_q != 2'd2);
	assign in_stall = !en;

	// ---------------- s1: offsets ----------------
	logic               v_s1;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] hd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 17'(target_x) - 17'(pose_x);
			dy_s1 <= 17'(target_y) - 17'(pose_y);
			hd_s1 <= heading;
		end
	end

	// ---------------- s2: squares ----------------
	logic               v_s2;
	logic signed [33:0] sqx_c, sqy_c;
	logic [32:0]        sqx_s2, sqy_s2;
	logic signed [16:0] dx_s2, dy_s2;
	logic signed [15:0] hd_s2;

	assign sqx_c = dx_s1 * dx_s1;
	assign sqy_c = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= sqx_c[32:0];
			sqy_s2 <= sqy_c[32:0];
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			hd_s2  <= hd_s1;
		end
	end

	// ---------------- s3: squared distance and arrival test ----------------
	logic               v_s3;
	logic [32:0]        d2_s3;
	logic               arr_s3;
	logic signed [16:0] dx_s3, dy_s3;
	logic signed [15:0] hd_s3;
	logic [32:0]        d2_c;
	logic [29:0]        stop2_c;

	assign d2_c    = sqx_s2 + sqy_s2;
	assign stop2_c = stop_distance_q * stop_distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3  <= d2_c;
			arr_s3 <= (d2_c < 33'(stop2_c));
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			hd_s3  <= hd_s2;
		end
	end

	// ---------------- cordic: sin and cos of the heading ----------------
	typedef struct packed {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic [32:0]        d2;
		logic               arr;
	} cor_side_t;

	cor_side_t            cor_in, cor_out;
	logic                 cor_v;
	logic signed [CW-1:0] cos_c, sin_c;

	assign cor_in = '{dx: dx_s3, dy: dy_s3, d2: d2_s3, arr: arr_s3};

	ppdc_cordic #(
		.STEPS (CORDIC_STEPS),
		.SW    ($bits(cor_side_t))
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.heading   (hd_s3),
		.side      (cor_in),
		.out_valid (cor_v),
		.cos_o     (cos_c),
		.sin_o     (sin_c),
		.side_out  (cor_out)
	);

	// ---------------- s4: rotation products ----------------
	logic               v_s4;
	logic signed [50:0] pc_c, ps_c;
	logic signed [50:0] pc_s4, ps_s4;
	logic [32:0]        d2_s4;
	logic               arr_s4;

	assign pc_c = cor_out.dy * cos_c;
	assign ps_c = cor_out.dx * sin_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= cor_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s4  <= pc_c;
			ps_s4  <= ps_c;
			d2_s4  <= cor_out.d2;
			arr_s4 <= cor_out.arr;
		end
	end

	// ---------------- s5: lateral offset in robot frame, q8 ----------------
	logic               v_s5;
	logic signed [51:0] lsum_c, lsh_c;
	logic signed [26:0] ly_s5;
	logic [32:0]        d2_s5;
	logic               arr_s5;

	assign lsum_c = 52'(pc_s4) - 52'(ps_s4) + 52'sd2097152;
	assign lsh_c  = lsum_c >>> 22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ly_s5  <= lsh_c[26:0];
			d2_s5  <= d2_s4;
			arr_s5 <= arr_s4;
		end
	end

	// ---------------- square root: distance in q8 ----------------
	typedef struct packed {
		logic signed [26:0] ly;
		logic [32:0]        d2;
		logic               arr;
	} sq_side_t;

	sq_side_t    sq_in, sq_out;
	logic        sq_v;
	logic [24:0] dq8_c;

	assign sq_in = '{ly: ly_s5, d2: d2_s5, arr: arr_s5};

	ppdc_sqrt #(
		.RW (25),
		.SW ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.radicand  ({1'b0, d2_s5, 16'd0}),
		.side      (sq_in),
		.out_valid (sq_v),
		.root      (dq8_c),
		.side_out  (sq_out)
	);

	// ---------------- s6: divider operands ----------------
	logic        v_s6;
	logic [25:0] lym_c;
	logic [42:0] ncv_s6, nsa_s6;
	logic [32:0] d2_s6, dq8_s6;
	logic        neg_s6, zr_s6, arr_s6;

	assign lym_c = sq_out.ly[26] ? 26'(-sq_out.ly) : sq_out.ly[25:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ncv_s6 <= {42'(lym_c) * 42'(curve_gain_q), 1'b0};
			nsa_s6 <= {1'b0, lym_c, 16'd0};
			d2_s6  <= sq_out.d2;
			dq8_s6 <= {8'd0, dq8_c};
			neg_s6 <= sq_out.ly[26];
			zr_s6  <= (sq_out.d2 == '0);
			arr_s6 <= sq_out.arr;
		end
	end

	// ---------------- curvature and sin(alpha) dividers ----------------
	typedef struct packed {
		logic neg;
		logic zr;
		logic arr;
	} cv_side_t;

	cv_side_t    cv_out;
	logic        cv_v, sa_v;
	logic [42:0] cvq_c, saq_c;

	ppdc_div #(
		.NW (43), .DW (33), .QW (43), .SW ($bits(cv_side_t))
	) u_div_curv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (ncv_s6),
		.den       (d2_s6),
		.side      ({neg_s6, zr_s6, arr_s6}),
		.out_valid (cv_v),
		.quo       (cvq_c),
		.side_out  (cv_out)
	);

	ppdc_div #(
		.NW (43), .DW (33), .QW (43), .SW (1)
	) u_div_sina (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (nsa_s6),
		.den       (dq8_s6),
		.side      (1'b0),
		.out_valid (sa_v),
		.quo       (saq_c),
		.side_out  ()
	);

	// ---------------- s7: slowdown term, sin(alpha) clamp ----------------
	logic        v_s7;
	logic [25:0] cvm_c;
	logic [16:0] sam_c;
	logic [41:0] dp_s7;
	logic [16:0] sam_s7;
	logic        neg_s7, arr_s7;

	// zero distance forces both quotients to zero
	assign cvm_c = cv_out.zr ? '0 : cvq_c[25:0];
	assign sam_c = cv_out.zr ? '0 :
		(saq_c > 43'd65536) ? 17'd65536 : saq_c[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= cv_v & sa_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s7  <= velocity_gain_q * cvm_c;
			sam_s7 <= sam_c;
			neg_s7 <= cv_out.neg;
			arr_s7 <= cv_out.arr;
		end
	end

	// ---------------- velocity divider, q8 ----------------
	typedef struct packed {
		logic        neg;
		logic [16:0] sam;
		logic        arr;
	} vd_side_t;

	vd_side_t    vd_out;
	logic        vd_v;
	logic [23:0] vq8_c;
	logic [42:0] vden_c;

	assign vden_c = 43'd16777216 + 43'(dp_s7);

	ppdc_div #(
		.NW (48), .DW (43), .QW (24), .SW ($bits(vd_side_t))
	) u_div_vel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       ({max_velocity_q, 32'd0}),
		.den       (vden_c),
		.side      ({neg_s7, sam_s7, arr_s7}),
		.out_valid (vd_v),
		.quo       (vq8_c),
		.side_out  (vd_out)
	);

	// ---------------- s8, s9: angular numerator ----------------
	logic        v_s8, v_s9;
	logic [32:0] p1_s8;
	logic [23:0] vq8_s8;
	logic [56:0] p2_s9;
	logic [15:0] lin_s8, lin_s9;
	logic        neg_s8, arr_s8, neg_s9, arr_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= vd_v;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s8  <= angular_gain_q * vd_out.sam;
			vq8_s8 <= vq8_c;
			lin_s8 <= vq8_c[23:8];
			neg_s8 <= vd_out.neg;
			arr_s8 <= vd_out.arr;
			p2_s9  <= p1_s8 * vq8_s8;
			lin_s9 <= lin_s8;
			neg_s9 <= neg_s8;
			arr_s9 <= arr_s8;
		end
	end

	// ---------------- angular divider by lookahead ----------------
	typedef struct packed {
		logic        neg;
		logic [15:0] lin;
		logic        arr;
	} ad_side_t;

	ad_side_t    ad_out;
	logic        ad_v;
	logic [33:0] aq_c;
	logic [14:0] la_c;

	// a zero lookahead acts as one
	assign la_c = (lookahead_q == '0) ? 15'd1 : lookahead_q;

	ppdc_div #(
		.NW (34), .DW (15), .QW (34), .SW ($bits(ad_side_t))
	) u_div_ang (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.num       (p2_s9[56:23]),
		.den       (la_c),
		.side      ({neg_s9, lin_s9, arr_s9}),
		.out_valid (ad_v),
		.quo       (aq_c),
		.side_out  (ad_out)
	);

	// ---------------- sign, saturation, arrival override ----------------
	typedef struct packed {
		logic [15:0]        lin;
		logic signed [23:0] ang;
		logic               arr;
	} res_t;

	res_t        res_c;
	logic [23:0] angp_c, angn_c;

	assign angp_c = (aq_c > 34'd8388607) ? 24'h7FFFFF : aq_c[23:0];
	assign angn_c = (aq_c > 34'd8388608) ? 24'h800000 : 24'd0 - aq_c[23:0];

	always_comb begin
		if (ad_out.arr) begin
			res_c = '{lin: '0, ang: '0, arr: 1'b1};
		end else begin
			res_c.lin = ad_out.lin;
			res_c.ang = ad_out.neg ? angn_c : angp_c;
			res_c.arr = 1'b0;
		end
	end

	// ---------------- output queue ----------------
	res_t ent_q [0:1];
	logic wp_q, rp_q;
	logic push, pop;

	assign push = ad_v & en;
	assign pop  = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= res_c;
		end
	end

	assign out_valid        = (cnt_q != 2'd0);
	assign linear_velocity  = ent_q[rp_q].lin;
	assign angular_velocity = ent_q[rp_q].ang;
	assign arrived          = ent_q[rp_q].arr;

endmodule

>>> rtl/ppdc_cordic.sv
module ppdc_cordic import ppdc_pkg::*; #(
	parameter int STEPS = 16,
	parameter int SW    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [15:0]   heading,
	input  logic [SW-1:0]        side,
	output logic                 out_valid,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o,
	output logic [SW-1:0]        side_out
);

	logic                 vld_s [0:STEPS];
	logic signed [CW-1:0] x_s   [0:STEPS];
	logic signed [CW-1:0] y_s   [0:STEPS];
	logic signed [CW-1:0] z_s   [0:STEPS];
	logic                 neg_s [0:STEPS];
	logic [SW-1:0]        sd_s  [0:STEPS];
	logic signed [CW-1:0] z_in;

	assign z_in = {{(CW-32){heading[15]}}, heading, 16'd0};

	// half-turn reduction into the convergence range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= INV_GAIN_Q30;
			y_s[0]  <= '0;
			sd_s[0] <= side;
			if (z_in > HALF_PI_Q29) begin
				z_s[0]   <= z_in - PI_Q29;
				neg_s[0] <= 1'b1;
			end else if (z_in < -HALF_PI_Q29) begin
				z_s[0]   <= z_in + PI_Q29;
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= z_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				sd_s[i+1]  <= sd_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - atan_q29(i);
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + atan_q29(i);
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign cos_o     = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_o     = neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	assign side_out  = sd_s[STEPS];

	// residual angle is not needed at the output
	logic unused_z;
	assign unused_z = ^z_s[STEPS];

endmodule

>>> rtl/ppdc_sqrt.sv
module ppdc_sqrt #(
	parameter int RW = 25,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] radicand,
	input  logic [SW-1:0]   side,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	logic            vld_s [0:RW];
	logic [RW:0]     rem_s [0:RW];
	logic [RW-1:0]   rt_s  [0:RW];
	logic [2*RW-1:0] nn_s  [0:RW];
	logic [SW-1:0]   sd_s  [0:RW];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;
	assign nn_s[0]  = radicand;
	assign sd_s[0]  = side;

	// one root bit per stage, two radicand bits brought down
	for (genvar i = 0; i < RW; i++) begin : g_step
		logic [RW+2:0] t;
		logic [RW+2:0] trial;
		logic          ge;
		assign t     = {rem_s[i], nn_s[i][2*RW-1 -: 2]};
		assign trial = {1'b0, rt_s[i], 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
				rt_s[i+1]  <= {rt_s[i][RW-2:0], ge};
				nn_s[i+1]  <= {nn_s[i][2*RW-3:0], 2'b00};
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = rt_s[RW];
	assign side_out  = sd_s[RW];

	logic unused_tail;
	assign unused_tail = ^{rem_s[RW], nn_s[RW]};

endmodule

>>> rtl/ppdc_div.sv
module ppdc_div #(
	parameter int NW = 43,
	parameter int DW = 33,
	parameter int QW = 43,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	// the top NW-QW numerator bits must already be below den
	logic          vld_s [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] nq_s  [0:QW];
	logic [DW-1:0] dd_s  [0:QW];
	logic [SW-1:0] sd_s  [0:QW];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = DW'(num >> QW);
	assign nq_s[0]  = num[QW-1:0];
	assign dd_s[0]  = den;
	assign sd_s[0]  = side;

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW:0] t;
		logic        ge;
		assign t  = {rem_s[i], nq_s[i][QW-1]};
		assign ge = (t >= {1'b0, dd_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? DW'(t - {1'b0, dd_s[i]}) : DW'(t);
				nq_s[i+1]  <= {nq_s[i][QW-2:0], ge};
				dd_s[i+1]  <= dd_s[i];
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = nq_s[QW];
	assign side_out  = sd_s[QW];

	logic unused_tail;
	assign unused_tail = ^{rem_s[QW], dd_s[QW]};

endmodule

>>> rtl/ppdc_checker.sv
module ppdc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        linear_velocity,
	input logic signed [23:0] angular_velocity,
	input logic               arrived
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(linear_velocity)
			&& $stable(angular_velocity) && $stable(arrived))
		else $error("stalled result changed");

	// arrival means both commands are zero
	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arrived |-> linear_velocity == '0 && angular_velocity == '0)
		else $error("arrived with nonzero command");

	// an empty output side never backpressures the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// nothing is offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered in reset");

	logic unused_in;
	assign unused_in = in_valid;

endmodule

bind pure_pursuit_drive_command_unit ppdc_checker u_ppdc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.linear_velocity  (linear_velocity),
	.angular_velocity (angular_velocity),
	.arrived          (arrived)
);
